/* hw/rtl/i2cm_pkg.sv */
// Package for the I2C master transaction sequencer: item structs, command,
// status, event, error and interrupt-enable codes, and buffer sizes.
// No dependencies.
package i2cm_pkg;

  // Transmit buffer and receive length sizing
  localparam int BUF_DEPTH = 16;
  localparam int BUF_IDX_W = $clog2(BUF_DEPTH);
  localparam int TX_CNT_W  = $clog2(BUF_DEPTH + 1);
  localparam int RX_MAX    = 16;
  localparam int RX_CNT_W  = $clog2(RX_MAX + 1);

  // Input commands
  localparam logic [2:0] CMD_LOAD  = 3'd0;
  localparam logic [2:0] CMD_BEGIN = 3'd1;
  localparam logic [2:0] CMD_EVENT = 3'd2;
  localparam logic [2:0] CMD_ERROR = 3'd3;
  localparam logic [2:0] CMD_TICK  = 3'd4;

  // Completion status codes
  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_OK      = 3'd1;
  localparam logic [2:0] ST_BUSY    = 3'd2;
  localparam logic [2:0] ST_BUS_ERR = 3'd3;
  localparam logic [2:0] ST_ARB     = 3'd4;
  localparam logic [2:0] ST_ACK     = 3'd5;
  localparam logic [2:0] ST_OVR     = 3'd6;
  localparam logic [2:0] ST_TIMEOUT = 3'd7;

  // Event flag bit positions
  localparam int EV_SB   = 0;
  localparam int EV_ADDR = 1;
  localparam int EV_TXE  = 2;
  localparam int EV_BTF  = 3;
  localparam int EV_RXNE = 4;
  localparam int EV_MSL  = 5;
  localparam int EV_TRA  = 6;

  // Error flag bit positions
  localparam int ER_BUS = 0;
  localparam int ER_ARB = 1;
  localparam int ER_AF  = 2;
  localparam int ER_OVR = 3;

  // Interrupt enable bit positions
  localparam int IRQ_BUF = 0;
  localparam int IRQ_ERR = 1;
  localparam int IRQ_EVT = 2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  byte_index;
    logic [7:0]  data_byte;
    logic [7:0]  data_byte_second;
    logic [7:0]  dev_addr;
    logic [4:0]  tx_len;
    logic [4:0]  rx_len;
    logic [15:0] timeout_ticks;
    logic        bus_busy;
    logic [6:0]  event_flags;
    logic [3:0]  error_flags;
  } in_item_t;

  typedef struct packed {
    logic       dr_write_valid;
    logic [7:0] dr_write_byte;
    logic       start_req;
    logic       stop_req;
    logic       ack_enable;
    logic       pos_enable;
    logic [2:0] irq_enables;
    logic [1:0] rx_store_count;
    logic [3:0] rx_index;
    logic [7:0] rx_byte_first;
    logic [7:0] rx_byte_second;
    logic [2:0] status;
  } out_item_t;

endpackage

/* hw/rtl/i2cm_in_stage.sv */
// Input register stage of the I2C master sequencer.
// Depends on i2cm_pkg (in_item_t).
module i2cm_in_stage
  import i2cm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     step,
  output logic     hold_valid,
  output in_item_t hold_item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  // Free when empty or when the held item moves on this cycle
  assign in_ready  = !valid_r || step;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;

endmodule

/* hw/rtl/i2cm_seq_core.sv */
// Transaction state and single-pass decision logic of the I2C master
// sequencer. Depends on i2cm_pkg.
module i2cm_seq_core
  import i2cm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  output out_item_t result
);

  logic [7:0]          tx_store [BUF_DEPTH];
  logic [TX_CNT_W-1:0] tx_sent_r, tx_sent_nxt, tx_total_r, tx_total_nxt;
  logic [RX_CNT_W-1:0] rx_got_r, rx_got_nxt, rx_total_r, rx_total_nxt;
  logic [7:0]          addr_r, addr_nxt;
  logic                ack_r, ack_nxt, pos_r, pos_nxt;
  logic [2:0]          irq_r, irq_nxt;
  logic [2:0]          perr_r, perr_nxt;
  logic [15:0]         ticks_r, ticks_nxt;
  logic                active_r, active_nxt;

  logic [RX_CNT_W-1:0] remain;
  logic [7:0]          tx_head_r;
  logic                tx_more;
  logic [2:0]          done_status;
  logic                load_we;

  // Store write on a load with an in-range index
  assign load_we = step && (item.cmd == CMD_LOAD) && (32'(item.byte_index) < BUF_DEPTH);

  always_ff @(posedge clk) begin
    if (load_we) begin
      tx_store[BUF_IDX_W'(item.byte_index)] <= item.data_byte;
    end
  end

  // Next byte to send, read ahead at the new send position; a load to that
  // same entry is passed straight through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_head_r <= tx_store[BUF_IDX_W'(0)];
    end else if (step) begin
      if (load_we && item.byte_index == tx_sent_nxt[BUF_IDX_W-1:0]) begin
        tx_head_r <= item.data_byte;
      end else begin
        tx_head_r <= tx_store[tx_sent_nxt[BUF_IDX_W-1:0]];
      end
    end
  end

  assign tx_more     = tx_sent_r < tx_total_r;
  assign remain      = (rx_got_r < rx_total_r) ? (rx_total_r - rx_got_r) : '0;
  assign done_status = (perr_r != ST_NONE) ? perr_r : ST_OK;

  // Decision logic for one item
  always_comb begin
    tx_sent_nxt  = tx_sent_r;
    tx_total_nxt = tx_total_r;
    rx_got_nxt   = rx_got_r;
    rx_total_nxt = rx_total_r;
    addr_nxt     = addr_r;
    ack_nxt      = ack_r;
    pos_nxt      = pos_r;
    irq_nxt      = irq_r;
    perr_nxt     = perr_r;
    ticks_nxt    = ticks_r;
    active_nxt   = active_r;
    result       = '0;

    unique case (item.cmd)
      CMD_BEGIN: begin
        if (active_r || item.bus_busy) begin
          result.status = ST_BUSY;
        end else begin
          tx_total_nxt = (32'(item.tx_len) > BUF_DEPTH) ? TX_CNT_W'(BUF_DEPTH)
                                                        : TX_CNT_W'(item.tx_len);
          rx_total_nxt = (32'(item.rx_len) > RX_MAX) ? RX_CNT_W'(RX_MAX)
                                                     : RX_CNT_W'(item.rx_len);
          tx_sent_nxt  = '0;
          rx_got_nxt   = '0;
          perr_nxt     = ST_NONE;
          addr_nxt     = item.dev_addr;
          ticks_nxt    = item.timeout_ticks;
          pos_nxt      = 1'b0;
          irq_nxt      = 3'b111;
          ack_nxt      = (rx_total_nxt != '0);
          result.start_req = 1'b1;
          active_nxt   = 1'b1;
        end
      end
      CMD_EVENT: begin
        if (active_r && item.event_flags[EV_MSL]) begin
          priority if (item.event_flags[EV_SB]) begin
            // Start sent: address byte, write or read direction
            result.dr_write_valid = 1'b1;
            result.dr_write_byte  = tx_more ? {addr_r[7:1], 1'b0} : {addr_r[7:1], 1'b1};
            irq_nxt[IRQ_BUF]      = 1'b1;
          end else if (item.event_flags[EV_ADDR]) begin
            // Address done: set up short read endings
            if (tx_sent_r == tx_total_r && rx_total_r == RX_CNT_W'(1)) begin
              ack_nxt         = 1'b0;
              result.stop_req = 1'b1;
            end else if (tx_sent_r == tx_total_r && rx_total_r == RX_CNT_W'(2)) begin
              ack_nxt = 1'b0;
              pos_nxt = 1'b1;
            end
          end else if (item.event_flags[EV_TRA]) begin
            // Transmitter side
            if (item.event_flags[EV_TXE] && irq_r[IRQ_BUF] && !item.event_flags[EV_BTF]) begin
              if (tx_more) begin
                result.dr_write_valid = 1'b1;
                result.dr_write_byte  = tx_head_r;
                tx_sent_nxt           = tx_sent_r + 1'b1;
              end else begin
                irq_nxt[IRQ_BUF] = 1'b0;
              end
            end else if (item.event_flags[EV_BTF] && irq_r[IRQ_EVT]) begin
              if (tx_more) begin
                result.dr_write_valid = 1'b1;
                result.dr_write_byte  = tx_head_r;
                tx_sent_nxt           = tx_sent_r + 1'b1;
              end else if (rx_total_r != '0) begin
                result.start_req = 1'b1;
              end else begin
                result.stop_req = 1'b1;
                irq_nxt         = '0;
                result.status   = done_status;
                active_nxt      = 1'b0;
              end
            end
          end else begin
            // Receiver side
            if (item.event_flags[EV_RXNE] && irq_r[IRQ_BUF] && !item.event_flags[EV_BTF]) begin
              if (remain > RX_CNT_W'(3)) begin
                result.rx_store_count = 2'd1;
                result.rx_index       = 4'(rx_got_r);
                result.rx_byte_first  = item.data_byte;
                rx_got_nxt            = rx_got_r + 1'b1;
              end else if (remain == RX_CNT_W'(2) || remain == RX_CNT_W'(3)) begin
                irq_nxt[IRQ_BUF] = 1'b0;
              end else begin
                irq_nxt = '0;
                if (remain == RX_CNT_W'(1)) begin
                  result.rx_store_count = 2'd1;
                  result.rx_index       = 4'(rx_got_r);
                  result.rx_byte_first  = item.data_byte;
                  rx_got_nxt            = rx_got_r + 1'b1;
                end
                result.status = done_status;
                active_nxt    = 1'b0;
              end
            end else if (item.event_flags[EV_BTF] && irq_r[IRQ_EVT]) begin
              if (remain == RX_CNT_W'(3)) begin
                ack_nxt               = 1'b0;
                result.rx_store_count = 2'd1;
                result.rx_index       = 4'(rx_got_r);
                result.rx_byte_first  = item.data_byte;
                rx_got_nxt            = rx_got_r + 1'b1;
              end else if (remain == RX_CNT_W'(2)) begin
                result.stop_req       = 1'b1;
                result.rx_store_count = 2'd2;
                result.rx_index       = 4'(rx_got_r);
                result.rx_byte_first  = item.data_byte;
                result.rx_byte_second = item.data_byte_second;
                rx_got_nxt            = rx_got_r + RX_CNT_W'(2);
                irq_nxt               = '0;
                result.status         = done_status;
                active_nxt            = 1'b0;
              end else if (remain != '0) begin
                result.rx_store_count = 2'd1;
                result.rx_index       = 4'(rx_got_r);
                result.rx_byte_first  = item.data_byte;
                rx_got_nxt            = rx_got_r + 1'b1;
                if (remain == RX_CNT_W'(1)) begin
                  irq_nxt       = '0;
                  result.status = done_status;
                  active_nxt    = 1'b0;
                end
              end
            end
          end
        end
      end
      CMD_ERROR: begin
        // Last flag in priority order wins
        if (active_r && irq_r[IRQ_ERR]) begin
          if (item.error_flags[ER_BUS]) perr_nxt = ST_BUS_ERR;
          if (item.error_flags[ER_ARB]) perr_nxt = ST_ARB;
          if (item.error_flags[ER_AF] && item.event_flags[EV_MSL]) perr_nxt = ST_ACK;
          if (item.error_flags[ER_OVR]) perr_nxt = ST_OVR;
        end
      end
      CMD_TICK: begin
        if (active_r) begin
          if (ticks_r <= 16'd1) begin
            ticks_nxt     = '0;
            active_nxt    = 1'b0;
            result.status = ST_TIMEOUT;
          end else begin
            ticks_nxt = ticks_r - 1'b1;
          end
        end
      end
      default: begin
        // Load and unknown commands change no control state
      end
    endcase

    result.ack_enable  = ack_nxt;
    result.pos_enable  = pos_nxt;
    result.irq_enables = irq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_sent_r  <= '0;
      tx_total_r <= '0;
      rx_got_r   <= '0;
      rx_total_r <= '0;
      addr_r     <= '0;
      ack_r      <= 1'b0;
      pos_r      <= 1'b0;
      irq_r      <= '0;
      perr_r     <= ST_NONE;
      ticks_r    <= '0;
      active_r   <= 1'b0;
    end else if (step) begin
      tx_sent_r  <= tx_sent_nxt;
      tx_total_r <= tx_total_nxt;
      rx_got_r   <= rx_got_nxt;
      rx_total_r <= rx_total_nxt;
      addr_r     <= addr_nxt;
      ack_r      <= ack_nxt;
      pos_r      <= pos_nxt;
      irq_r      <= irq_nxt;
      perr_r     <= perr_nxt;
      ticks_r    <= ticks_nxt;
      active_r   <= active_nxt;
    end
  end

endmodule

/* hw/rtl/i2cm_out_stage.sv */
// Result register stage of the I2C master sequencer.
// Depends on i2cm_pkg (out_item_t).
module i2cm_out_stage
  import i2cm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      hold_valid,
  input  out_item_t result,
  output logic      step,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  // Advance when the result register is empty or is being drained
  assign step      = hold_valid && (!valid_r || out_ready);
  assign valid_nxt = step || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      item_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

/* hw/rtl/i2c_master_transaction_sequencer_unit.sv */
// I2C master transaction sequencer, top level.
// Depends on i2cm_pkg, i2cm_in_stage, i2cm_seq_core, i2cm_out_stage.
//
// Usage:
//   in_valid/in_ready/in_item carry commands: load a transmit byte, begin a
//   write-then-read transaction, report controller status flags, report
//   error flags, or a timeout tick. Every item yields exactly one result on
//   out_valid/out_ready/out_item: data-register write, start/stop requests,
//   ACK/POS/interrupt-enable levels, received bytes and completion status.
//   Path: an accepted item waits in the input register; its result is
//   registered in the result register.
//   Throughput: one item per cycle unless stalled; all decisions for an
//   item are made in one pass between the input and result registers.
//   Stall: while out_ready is low the result holds; one more item waits in
//   the input register, then in_ready drops until the result is taken.
//   Reset (rst_n low, synchronous): both stages empty, transaction idle,
//   all levels and counters zero. The transmit store is not cleared.
module i2c_master_transaction_sequencer_unit
  import i2cm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      step;
  logic      hold_valid;
  in_item_t  hold_item;
  out_item_t result;

  i2cm_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .step       (step),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  i2cm_seq_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (hold_item),
    .result (result)
  );

  i2cm_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold_valid (hold_valid),
    .result     (result),
    .step       (step),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

/* hw/rtl/i2cm_checker.sv */
// Port-level checks for the I2C master sequencer, bound to the top level.
// Depends on i2cm_pkg and i2c_master_transaction_sequencer_unit.
module i2cm_checker
  import i2cm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  // Reset empties the result stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A waiting input item holds until accepted
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_item))
    else $error("waiting input item changed");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // No data-register byte without a write
  a_dr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.dr_write_valid |-> out_item.dr_write_byte == 8'd0)
    else $error("data byte without write");

  // Receive fields are zero when nothing is delivered; never three bytes
  a_rx_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.rx_store_count != 2'd3) &&
                  (out_item.rx_store_count != 2'd0 ||
                   (out_item.rx_index == 4'd0 && out_item.rx_byte_first == 8'd0 &&
                    out_item.rx_byte_second == 8'd0)))
    else $error("inconsistent receive fields");

endmodule

bind i2c_master_transaction_sequencer_unit i2cm_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

/* bench/tb_i2c_master_transaction_sequencer_unit.sv */
// Self-checking bench for i2c_master_transaction_sequencer_unit: directed and random
// write-then-read transactions, checked item by item against an in-bench predictor.
// Depends on i2cm_pkg and the sequencer RTL.
module tb_i2c_master_transaction_sequencer_unit;
  import i2cm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1750;
  localparam int QUIET_ITEMS    = 175;

  // Command code the block does not know
  localparam logic [2:0] CMD_UNKNOWN = 3'd7;

  // Single event flag masks
  localparam logic [6:0] F_SB   = 7'b1 << EV_SB;
  localparam logic [6:0] F_ADDR = 7'b1 << EV_ADDR;
  localparam logic [6:0] F_TXE  = 7'b1 << EV_TXE;
  localparam logic [6:0] F_BTF  = 7'b1 << EV_BTF;
  localparam logic [6:0] F_RXNE = 7'b1 << EV_RXNE;
  localparam logic [6:0] F_MSL  = 7'b1 << EV_MSL;
  localparam logic [6:0] F_TRA  = 7'b1 << EV_TRA;

  typedef enum int {TXN_CLEAN, TXN_NOISY, TXN_BROKEN} txn_mode_e;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  i2c_master_transaction_sequencer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // Predicted sequencer state, same reset values as the block
  logic [7:0]  tx_bytes [BUF_DEPTH];
  logic [4:0]  bytes_sent = '0;
  logic [4:0]  bytes_got = '0;
  logic [4:0]  write_len = '0;
  logic [4:0]  read_len = '0;
  logic [7:0]  addr_byte = '0;
  logic        ack_lvl = 1'b0;
  logic        pos_lvl = 1'b0;
  logic [2:0]  irq_lvl = '0;
  logic [2:0]  err_code = ST_NONE;
  logic [15:0] ticks_remaining = '0;
  logic        busy_txn = 1'b0;

  out_item_t   expected_actions [$];
  out_item_t   want;
  int          errors = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;

  // Ends the transaction: stored error if any, else success
  function automatic logic [2:0] close_txn();
    busy_txn = 1'b0;
    return (err_code != ST_NONE) ? err_code : ST_OK;
  endfunction

  // Expected controller actions for one accepted item; updates predicted state
  function automatic out_item_t predict_action(input in_item_t it);
    out_item_t  r;
    logic [6:0] ev;
    logic [4:0] left;
    logic [1:0] take;
    logic       done;
    logic       txe, btf, rxne;
    r    = '0;
    ev   = it.event_flags;
    txe  = ev[EV_TXE];
    btf  = ev[EV_BTF];
    rxne = ev[EV_RXNE];
    take = 2'd0;
    done = 1'b0;
    left = (bytes_got < read_len) ? read_len - bytes_got : 5'd0;
    case (it.cmd)
      CMD_LOAD: begin
        tx_bytes[it.byte_index] = it.data_byte;
      end
      CMD_BEGIN: begin
        if (busy_txn || it.bus_busy) begin
          r.status = ST_BUSY;
        end else begin
          write_len       = (it.tx_len > BUF_DEPTH) ? 5'(BUF_DEPTH) : it.tx_len;
          read_len        = (it.rx_len > RX_MAX) ? 5'(RX_MAX) : it.rx_len;
          bytes_sent      = '0;
          bytes_got       = '0;
          err_code        = ST_NONE;
          addr_byte       = it.dev_addr;
          ticks_remaining = it.timeout_ticks;
          pos_lvl         = 1'b0;
          irq_lvl         = '1;
          ack_lvl         = (read_len != 0);
          r.start_req     = 1'b1;
          busy_txn        = 1'b1;
        end
      end
      CMD_EVENT: begin
        if (busy_txn && ev[EV_MSL]) begin
          if (ev[EV_SB]) begin
            // address phase: write direction while bytes remain to send
            r.dr_write_valid = 1'b1;
            r.dr_write_byte  = {addr_byte[7:1], !(bytes_sent < write_len)};
            irq_lvl[IRQ_BUF] = 1'b1;
          end else if (ev[EV_ADDR]) begin
            if (bytes_sent == write_len && read_len == 1) begin
              ack_lvl    = 1'b0;
              r.stop_req = 1'b1;
            end else if (bytes_sent == write_len && read_len == 2) begin
              ack_lvl = 1'b0;
              pos_lvl = 1'b1;
            end
          end else if (ev[EV_TRA]) begin
            // transmitter side
            if (txe && irq_lvl[IRQ_BUF] && !btf) begin
              if (bytes_sent < write_len) begin
                r.dr_write_valid = 1'b1;
                r.dr_write_byte  = tx_bytes[bytes_sent[3:0]];
                bytes_sent++;
              end else begin
                irq_lvl[IRQ_BUF] = 1'b0;
              end
            end else if (btf && irq_lvl[IRQ_EVT]) begin
              if (bytes_sent < write_len) begin
                r.dr_write_valid = 1'b1;
                r.dr_write_byte  = tx_bytes[bytes_sent[3:0]];
                bytes_sent++;
              end else if (read_len != 0) begin
                r.start_req = 1'b1;
              end else begin
                r.stop_req = 1'b1;
                irq_lvl    = '0;
                done       = 1'b1;
              end
            end
          end else begin
            // receiver side: one, two and three-or-more byte endings
            if (rxne && irq_lvl[IRQ_BUF] && !btf) begin
              if (left > 3) begin
                take = 2'd1;
              end else if (left == 2 || left == 3) begin
                irq_lvl[IRQ_BUF] = 1'b0;
              end else begin
                irq_lvl = '0;
                take    = (left == 1) ? 2'd1 : 2'd0;
                done    = 1'b1;
              end
            end else if (btf && irq_lvl[IRQ_EVT]) begin
              if (left == 3) begin
                ack_lvl = 1'b0;
                take    = 2'd1;
              end else if (left == 2) begin
                r.stop_req = 1'b1;
                take       = 2'd2;
                irq_lvl    = '0;
                done       = 1'b1;
              end else if (left > 0) begin
                take = 2'd1;
                if (left == 1) begin
                  irq_lvl = '0;
                  done    = 1'b1;
                end
              end
            end
            if (take != 0) begin
              r.rx_store_count = take;
              r.rx_index       = bytes_got[3:0];
              r.rx_byte_first  = it.data_byte;
              if (take == 2) r.rx_byte_second = it.data_byte_second;
              bytes_got = bytes_got + take;
            end
          end
          if (done) r.status = close_txn();
        end
      end
      CMD_ERROR: begin
        // later flags override earlier ones; ack failure needs master mode
        if (busy_txn && irq_lvl[IRQ_ERR]) begin
          if (it.error_flags[ER_BUS]) err_code = ST_BUS_ERR;
          if (it.error_flags[ER_ARB]) err_code = ST_ARB;
          if (it.error_flags[ER_AF] && ev[EV_MSL]) err_code = ST_ACK;
          if (it.error_flags[ER_OVR]) err_code = ST_OVR;
        end
      end
      CMD_TICK: begin
        if (busy_txn) begin
          if (ticks_remaining <= 1) begin
            ticks_remaining = '0;
            busy_txn        = 1'b0;
            r.status        = ST_TIMEOUT;
          end else begin
            ticks_remaining--;
          end
        end
      end
      default: ;
    endcase
    r.ack_enable  = ack_lvl;
    r.pos_enable  = pos_lvl;
    r.irq_enables = irq_lvl;
    return r;
  endfunction

  // Predict every accepted item
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) expected_actions.push_back(predict_action(in_item));
  end

  task automatic check_field(input string name, input logic [7:0] e, input logic [7:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, e, a);
    end
  endtask

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_actions.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: expected none, actual %h", $time,
                 out_item);
      end else begin
        want = expected_actions.pop_front();
        check_field("dr_write_valid", 8'(want.dr_write_valid), 8'(out_item.dr_write_valid));
        check_field("dr_write_byte", want.dr_write_byte, out_item.dr_write_byte);
        check_field("start_req", 8'(want.start_req), 8'(out_item.start_req));
        check_field("stop_req", 8'(want.stop_req), 8'(out_item.stop_req));
        check_field("ack_enable", 8'(want.ack_enable), 8'(out_item.ack_enable));
        check_field("pos_enable", 8'(want.pos_enable), 8'(out_item.pos_enable));
        check_field("irq_enables", 8'(want.irq_enables), 8'(out_item.irq_enables));
        check_field("rx_store_count", 8'(want.rx_store_count), 8'(out_item.rx_store_count));
        check_field("rx_index", 8'(want.rx_index), 8'(out_item.rx_index));
        check_field("rx_byte_first", want.rx_byte_first, out_item.rx_byte_first);
        check_field("rx_byte_second", want.rx_byte_second, out_item.rx_byte_second);
        check_field("status", 8'(want.status), 8'(out_item.status));
      end
    end
  end

  // Result side back-pressure in random bursts
  always @(posedge clk) begin
    if (!stalls_on) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 13);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no handshake for %0d cycles", $time, idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Drive one item and hold it until accepted, then maybe leave a gap
  task automatic send_item(input in_item_t it);
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_actions.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic in_item_t blank_item(input logic [2:0] c);
    in_item_t it;
    it     = '0;
    it.cmd = c;
    return it;
  endfunction

  function automatic in_item_t random_item(input logic [2:0] c);
    in_item_t    it;
    logic [95:0] raw;
    raw    = {$urandom(), $urandom(), $urandom()};
    it     = raw[$bits(in_item_t)-1:0];
    it.cmd = c;
    return it;
  endfunction

  function automatic in_item_t event_item(input logic [6:0] flags);
    in_item_t it;
    it             = random_item(CMD_EVENT);
    it.event_flags = flags;
    return it;
  endfunction

  // Every store entry written before any transmit can read it
  task automatic test_fill_store();
    in_item_t it;
    for (int i = 0; i < BUF_DEPTH; i++) begin
      it            = blank_item(CMD_LOAD);
      it.byte_index = 4'(i);
      it.data_byte  = (i == 0) ? 8'h00 : (i == BUF_DEPTH - 1) ? 8'hFF : 8'($urandom);
      send_item(it);
    end
    wait_drained();
  endtask

  // Status, error, tick and unknown commands with no transaction running
  task automatic test_idle_events();
    in_item_t it;
    send_item(event_item(F_MSL | F_RXNE));
    it             = blank_item(CMD_ERROR);
    it.error_flags = 4'hF;
    it.event_flags = F_MSL;
    send_item(it);
    send_item(blank_item(CMD_TICK));
    send_item(random_item(CMD_UNKNOWN));
    wait_drained();
  endtask

  // Busy bus refuses; an empty transaction completes on a receive event
  task automatic test_busy_refusal();
    in_item_t it;
    it               = blank_item(CMD_BEGIN);
    it.bus_busy      = 1'b1;
    it.rx_len        = 5'd2;
    it.timeout_ticks = 16'd100;
    send_item(it);
    it.bus_busy = 1'b0;
    it.rx_len   = 5'd0;
    send_item(it);
    send_item(event_item(F_MSL | F_RXNE));
    wait_drained();
  endtask

  // Saturated lengths, begin while active, slave-mode events, then timeout
  task automatic test_timeout();
    in_item_t it;
    it               = blank_item(CMD_BEGIN);
    it.tx_len        = 5'd31;
    it.rx_len        = 5'd31;
    it.dev_addr      = 8'hFF;
    it.timeout_ticks = 16'd2;
    send_item(it);
    send_item(it);
    send_item(event_item(F_SB));
    it             = blank_item(CMD_ERROR);
    it.error_flags = 4'(1 << ER_AF);
    send_item(it);
    send_item(blank_item(CMD_TICK));
    send_item(blank_item(CMD_TICK));
    wait_drained();
  endtask

  // Last error wins and is reported when a one-byte read completes
  task automatic test_error_report();
    in_item_t it;
    it               = blank_item(CMD_BEGIN);
    it.rx_len        = 5'd1;
    it.timeout_ticks = 16'hFFFF;
    send_item(it);
    it             = blank_item(CMD_ERROR);
    it.error_flags = 4'(1 << ER_AF);
    it.event_flags = F_MSL;
    send_item(it);
    it.error_flags = 4'hF;
    send_item(it);
    send_item(event_item(F_MSL | F_SB));
    send_item(event_item(F_MSL | F_ADDR));
    it           = event_item(F_MSL | F_RXNE);
    it.data_byte = 8'hFF;
    send_item(it);
    wait_drained();
  endtask

  // One random transaction: well-formed, with noise, or cut short;
  // only well-formed ones in the quiet part so the input never idles
  task automatic run_transaction(input bit quiet);
    in_item_t   it;
    logic [6:0] steps [$];
    txn_mode_e  mode;
    int         pick, tl, rl, left, cut, n;
    pick = $urandom_range(0, 9);
    mode = (pick < 7) ? TXN_CLEAN : (pick < 9) ? TXN_NOISY : TXN_BROKEN;
    if (quiet) mode = TXN_CLEAN;

    repeat ($urandom_range(0, 3)) send_item(random_item(CMD_LOAD));

    it          = random_item(CMD_BEGIN);
    it.bus_busy = (mode == TXN_NOISY) && ($urandom_range(0, 7) == 0);
    it.tx_len   = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31))
                                              : 5'($urandom_range(0, 16));
    it.rx_len   = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31))
                                              : 5'($urandom_range(0, 16));
    if (mode == TXN_CLEAN)
      it.timeout_ticks = ($urandom_range(0, 15) == 0) ? 16'hFFFF : 16'($urandom_range(64, 65535));
    else
      it.timeout_ticks = 16'($urandom_range(0, 40));
    send_item(it);
    tl = (it.tx_len > BUF_DEPTH) ? BUF_DEPTH : it.tx_len;
    rl = (it.rx_len > RX_MAX) ? RX_MAX : it.rx_len;

    // Write phase, skipped for a pure read
    if (tl > 0 || rl == 0) begin
      steps.push_back(F_MSL | F_SB);
      steps.push_back(F_MSL | F_ADDR | F_TRA);
      repeat (tl) steps.push_back(F_MSL | F_TRA | F_TXE);
      steps.push_back(F_MSL | F_TRA | F_TXE);
      steps.push_back(F_MSL | F_TRA | F_TXE | F_BTF);
    end
    // Read phase with the ending that matches the length
    if (rl > 0) begin
      steps.push_back(F_MSL | F_SB);
      steps.push_back(F_MSL | F_ADDR);
      left = rl;
      while (left > 3) begin
        steps.push_back(F_MSL | F_RXNE);
        left--;
      end
      steps.push_back(F_MSL | F_RXNE);
      if (left >= 2) steps.push_back(F_MSL | F_RXNE | F_BTF);
      if (left == 3) steps.push_back(F_MSL | F_RXNE | F_BTF);
    end

    cut = (mode == TXN_BROKEN) ? $urandom_range(0, steps.size() - 1) : steps.size();
    for (int i = 0; i < cut; i++) begin
      if (mode == TXN_NOISY && $urandom_range(0, 5) == 0) begin
        it = random_item(3'($urandom_range(0, 7)));
        if (it.cmd == CMD_BEGIN) it.timeout_ticks = 16'($urandom_range(0, 15));
        send_item(it);
      end else if (mode == TXN_CLEAN && $urandom_range(0, 23) == 0) begin
        send_item(random_item($urandom_range(0, 1) ? CMD_ERROR : CMD_TICK));
      end
      send_item(event_item(steps[i]));
    end

    // A disturbed transaction may still run: tick it out
    if (mode != TXN_CLEAN) begin
      wait_drained();
      if (busy_txn) begin
        n = (ticks_remaining > 1) ? ticks_remaining : 1;
        repeat (n) send_item(random_item(CMD_TICK));
      end
    end
  endtask

  task automatic test_random_traffic();
    int base;
    bit quiet;
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      quiet = (items_sent - base >= RANDOM_ITEMS - QUIET_ITEMS);
      if (quiet) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end else begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      run_transaction(quiet);
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_fill_store();
    test_idle_events();
    test_busy_refusal();
    test_timeout();
    test_error_report();
    test_random_traffic();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
